/* rtl/mast_pkg.sv */
// Shared types and constants for the MAC address set table.
// No dependencies; every other file in rtl/ imports this package.
package mast_pkg;

    localparam int MAC_W        = 48;
    localparam int ENTRY_W      = MAC_W + 1;   // valid mark over the address
    localparam int COUNT_OUT_W  = 7;
    localparam int DEF_CAPACITY = 64;

    // Operation codes carried on the kind port
    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_UPDATE
    } state_t;

    // Memory port control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

/* rtl/mast_mem.sv */
// Entry memory of the MAC address set table: one shared address port,
// synchronous write and registered read. Depends on mast_pkg.
module mast_mem #(
    parameter int CAPACITY = mast_pkg::DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                        clk,
    input  mast_pkg::mem_ctl_t          ctl,
    input  logic [IDX_W-1:0]            addr,
    input  logic [mast_pkg::ENTRY_W-1:0] wdata,
    output logic [mast_pkg::ENTRY_W-1:0] rdata
);
    import mast_pkg::*;

    logic [ENTRY_W-1:0] mem_array [CAPACITY];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_array[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_array[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/mast_ctrl.sv */
// Sequencer of the MAC address set table: clearing sweep, scan of all
// entries, write back and result. Depends on mast_pkg; drives mast_mem.
module mast_ctrl #(
    parameter int CAPACITY = mast_pkg::DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [1:0]                      kind,
    input  logic [mast_pkg::MAC_W-1:0]      mac,
    output logic                            busy,
    output logic                            done,
    output logic                            found,
    output logic                            status,
    output logic [mast_pkg::COUNT_OUT_W-1:0] entry_count,
    output mast_pkg::mem_ctl_t              mem_ctl,
    output logic [IDX_W-1:0]                mem_addr,
    output logic [mast_pkg::ENTRY_W-1:0]    mem_wdata,
    input  logic [mast_pkg::ENTRY_W-1:0]    mem_rdata
);
    import mast_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    state_t             state_reg, state_next;
    logic               clr_reply_reg, clr_reply_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic               cmp_last_reg, cmp_last_next;
    logic               hit_seen_reg, hit_seen_next;
    logic               free_seen_reg, free_seen_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic               status_reg, status_next;

    kind_t              kind_reg, kind_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               entry_valid;
    logic               entry_match;

    assign entry_valid = mem_rdata[ENTRY_W-1];
    assign entry_match = (mem_rdata[MAC_W-1:0] == mac_reg);

    // Control state; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reply_reg  <= 1'b0;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            hit_seen_reg   <= 1'b0;
            free_seen_reg  <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            status_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reply_reg  <= clr_reply_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_last_reg   <= cmp_last_next;
            hit_seen_reg   <= hit_seen_next;
            free_seen_reg  <= free_seen_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        mac_reg      <= mac_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    // Next state, memory accesses and result
    always_comb
    begin
        state_next      = state_reg;
        clr_reply_next  = clr_reply_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        cmp_vld_next    = 1'b0;
        cmp_last_next   = 1'b0;
        hit_seen_next   = hit_seen_reg;
        free_seen_next  = free_seen_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        status_next     = status_reg;
        kind_next       = kind_reg;
        mac_next        = mac_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        mem_ctl.wr_en   = 1'b0;
        mem_ctl.rd_en   = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Take a new command
                if (start)
                begin
                    kind_next       = kind_t'(kind);
                    mac_next        = mac;
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    hit_seen_next   = 1'b0;
                    free_seen_next  = 1'b0;
                    if (kind_t'(kind) == KIND_CLEAR)
                    begin
                        clr_reply_next = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_CLEAR:
            begin
                // Drop the valid mark of one entry per cycle
                mem_ctl.wr_en = 1'b1;
                mem_addr      = idx_reg;
                mem_wdata     = '0;
                idx_next      = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next       = '0;
                    count_next     = '0;
                    clr_reply_next = 1'b0;
                    state_next     = S_IDLE;
                    if (clr_reply_reg)
                    begin
                        done_next   = 1'b1;
                        found_next  = 1'b0;
                        status_next = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle
                if (!issue_done_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_addr      = idx_reg;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = idx_reg;
                    cmp_last_next = (idx_reg == LAST_IDX);
                    idx_next      = idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                        idx_next        = '0;
                    end
                end
                // Compare the entry read last cycle
                if (cmp_vld_reg)
                begin
                    if (entry_valid && entry_match && !hit_seen_reg)
                    begin
                        hit_seen_next = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                    end
                    if (!entry_valid && !free_seen_reg)
                    begin
                        free_seen_next = 1'b1;
                        free_idx_next  = cmp_idx_reg;
                    end
                    if (cmp_last_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end

            S_UPDATE:
            begin
                // Write back the changed entry and report
                done_next   = 1'b1;
                found_next  = hit_seen_reg;
                status_next = 1'b0;
                state_next  = S_IDLE;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (!hit_seen_reg)
                        begin
                            if (free_seen_reg)
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_addr      = free_idx_reg;
                                mem_wdata     = {1'b1, mac_reg};
                                count_next    = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (hit_seen_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            mem_addr      = hit_idx_reg;
                            mem_wdata     = {1'b0, mac_reg};
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        // lookup changes nothing
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_OUT_W'(count_reg);

    // One strobe per command
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    // A dropped add never reports a present address
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> !found_reg)
        else $error("table full reported with address present");

    // The count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // The shared memory port never reads and writes together
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("memory read and write in the same cycle");

    // An accepted command keeps the block busy next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

endmodule

/* rtl/mac_address_set_table_unit.sv */
// Top level of the MAC address set table: sequencer plus entry memory.
// Depends on mast_pkg, mast_mem and mast_ctrl.
//
// Usage:
//   A command (kind, mac) transfers at a rising edge where start is high and
//   busy is low. kind selects add, remove, lookup or clear. Every command
//   gives exactly one result: found, status and entry_count, shown for one
//   cycle with done high. The receiver cannot stall; it must take the result
//   in that cycle.
//   Add, remove and lookup walk every entry of the memory, one read per cycle
//   through the single memory port, compare the last entry, then write back
//   any changed entry in the update state, from which done is registered.
//   Clear sweeps the memory writing one entry per cycle; done is registered
//   from the write of the last entry.
//   busy drops in the cycle that done is high, so the next command may
//   transfer at the edge that ends it; one command is in work at a time.
//   After reset the block runs the same clearing sweep with busy high and
//   no result, then accepts commands.
//   An add of a new address to a full table is dropped and reports status 1.
module mac_address_set_table_unit #(
    parameter int CAPACITY = mast_pkg::DEF_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       kind,
    input  logic [mast_pkg::MAC_W-1:0]       mac,
    output logic                             done,
    output logic                             found,
    output logic                             status,
    output logic [mast_pkg::COUNT_OUT_W-1:0] entry_count
);
    import mast_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    // Sequencer
    mast_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .mac         (mac),
        .busy        (busy),
        .done        (done),
        .found       (found),
        .status      (status),
        .entry_count (entry_count),
        .mem_ctl     (mem_ctl),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata)
    );

    // Entry memory
    mast_mem #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

/* tb/tb_mac_address_set_table_unit.sv */
// Testbench for mac_address_set_table_unit: directed script, table fill, then random commands.
// Depends on mast_pkg and the RTL top level; results are checked against hand-written values or an in-bench model.
module tb_mac_address_set_table_unit;
    import mast_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int RANDOM_CMDS    = 510;
    localparam int QUIET_TAIL     = 100;
    localparam int WATCHDOG_LIMIT = 20 * (CAPACITY + 3 + 19);
    localparam int SCRIPT_LEN     = 20;

    localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};

    typedef struct packed {
        logic                   found;
        logic                   status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } table_result_t;

    typedef struct packed {
        kind_t            op;
        logic [MAC_W-1:0] addr;
        logic             fixed;   // want holds a hand-written result
        table_result_t    want;
    } script_row_t;

    // Directed commands; rows without a fixed result take the model's answer
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{KIND_LOOKUP, 48'h0,            1'b1, '{1'b0, 1'b0, 7'd0}},
        '{KIND_REMOVE, MAC_ONES,         1'b1, '{1'b0, 1'b0, 7'd0}},
        '{KIND_ADD,    48'h0,            1'b1, '{1'b0, 1'b0, 7'd1}},
        '{KIND_ADD,    MAC_ONES,         1'b1, '{1'b0, 1'b0, 7'd2}},
        '{KIND_ADD,    48'h0,            1'b1, '{1'b1, 1'b0, 7'd2}},
        '{KIND_LOOKUP, MAC_ONES,         1'b1, '{1'b1, 1'b0, 7'd2}},
        '{KIND_LOOKUP, 48'h1,            1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_ADD,    48'hAAAAAAAAAAAA, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_ADD,    48'h555555555555, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_REMOVE, 48'h0,            1'b1, '{1'b1, 1'b0, 7'd3}},
        '{KIND_REMOVE, 48'h0,            1'b1, '{1'b0, 1'b0, 7'd3}},
        '{KIND_ADD,    48'h800000000000, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_LOOKUP, 48'h555555555555, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_REMOVE, 48'h7FFFFFFFFFFF, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_CLEAR,  MAC_ONES,         1'b1, '{1'b0, 1'b0, 7'd0}},
        '{KIND_LOOKUP, 48'hAAAAAAAAAAAA, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{KIND_CLEAR,  48'h0,            1'b1, '{1'b0, 1'b0, 7'd0}},
        '{KIND_ADD,    48'h123456789ABC, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_LOOKUP, 48'h123456789ABC, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{KIND_CLEAR,  48'h123456789ABC, 1'b1, '{1'b0, 1'b0, 7'd0}}
    };

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   start       = 1'b0;
    logic [1:0]             kind        = KIND_LOOKUP;
    logic [MAC_W-1:0]       mac         = '0;
    logic                   busy;
    logic                   done;
    logic                   found;
    logic                   status;
    logic [COUNT_OUT_W-1:0] entry_count;

    // Model of the address table
    logic [MAC_W-1:0] entry_addr  [CAPACITY];
    logic             entry_valid [CAPACITY];
    int               entry_total;

    table_result_t pending_results [$];
    int            error_total  = 0;
    int            quiet_cycles = 0;
    logic          idle_on      = 1'b1;

    mac_address_set_table_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .mac        (mac),
        .done       (done),
        .found      (found),
        .status     (status),
        .entry_count(entry_count)
    );

    always #1 clk = ~clk;

    // Index of the valid entry holding addr, or -1
    function automatic int find_entry(input logic [MAC_W-1:0] addr);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (entry_valid[i] && entry_addr[i] == addr)
                return i;
        end
        return -1;
    endfunction

    // Apply one command to the model and return its result
    function automatic table_result_t apply_command(input kind_t op,
                                                    input logic [MAC_W-1:0] addr);
        table_result_t r;
        int            hit;
        int            slot;
        r    = '0;
        slot = -1;
        if (op == KIND_CLEAR)
        begin
            for (int i = 0; i < CAPACITY; i++)
                entry_valid[i] = 1'b0;
            entry_total = 0;
        end
        else
        begin
            hit     = find_entry(addr);
            r.found = (hit >= 0);
            if (op == KIND_ADD && hit < 0)
            begin
                // take the lowest free entry, or flag the table full
                for (int i = CAPACITY - 1; i >= 0; i--)
                begin
                    if (!entry_valid[i])
                        slot = i;
                end
                if (slot >= 0)
                begin
                    entry_addr[slot]  = addr;
                    entry_valid[slot] = 1'b1;
                    entry_total++;
                end
                else
                    r.status = 1'b1;
            end
            else if (op == KIND_REMOVE && hit >= 0)
            begin
                entry_valid[hit] = 1'b0;
                entry_total--;
            end
        end
        r.entry_count = entry_total[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // Random address not in the table
    function automatic logic [MAC_W-1:0] fresh_mac();
        logic [MAC_W-1:0] a;
        a = random_mac();
        while (find_entry(a) >= 0)
            a = random_mac();
        return a;
    endfunction

    // Random stored address; the table must not be empty
    function automatic logic [MAC_W-1:0] stored_mac();
        int idx;
        idx = $urandom_range(CAPACITY - 1);
        while (!entry_valid[idx])
            idx = (idx + 1) % CAPACITY;
        return entry_addr[idx];
    endfunction

    // Idle gap before the next command; none near the end of the run
    function automatic int next_gap(input int left);
        if ($urandom_range(29) == 0)
            idle_on = ~idle_on;
        if (!idle_on || left <= QUIET_TAIL || $urandom_range(3) != 0)
            return 0;
        return $urandom_range(19, 1);
    endfunction

    // Drive one command and hold it until the transfer, then log its result
    task automatic issue(input kind_t op, input logic [MAC_W-1:0] addr, input int gap,
                         input logic fixed, input table_result_t want);
        table_result_t r;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= op;
        mac   <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = apply_command(op, addr);
        pending_results.push_back(fixed ? want : r);
    endtask

    task automatic issue_modeled(input kind_t op, input logic [MAC_W-1:0] addr,
                                 input int gap);
        issue(op, addr, gap, 1'b0, '0);
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        table_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: found=%0d status=%0d entry_count=%0d",
                       found, status, entry_count);
                error_total++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    error_total++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_total++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, entry_count);
                    error_total++;
                end
            end
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int    pick;
        kind_t op;
        logic  grow;
        logic [MAC_W-1:0] addr;
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_valid[i] = 1'b0;
            entry_addr[i]  = '0;
        end
        entry_total = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
            issue(SCRIPT[i].op, SCRIPT[i].addr, next_gap(RANDOM_CMDS + QUIET_TAIL),
                  SCRIPT[i].fixed, SCRIPT[i].want);

        // fill the table, hit it full, then free one entry and refill
        issue(KIND_CLEAR, random_mac(), 0, 1'b1, '{1'b0, 1'b0, 7'd0});
        for (int i = 0; i < CAPACITY; i++)
            issue_modeled(KIND_ADD, fresh_mac(), next_gap(RANDOM_CMDS + QUIET_TAIL));
        issue(KIND_ADD, fresh_mac(), 0, 1'b1, '{1'b0, 1'b1, 7'(CAPACITY)});
        issue_modeled(KIND_ADD, stored_mac(), 0);
        issue_modeled(KIND_LOOKUP, stored_mac(), 0);
        issue_modeled(KIND_REMOVE, stored_mac(), 0);
        issue_modeled(KIND_ADD, fresh_mac(), 0);
        issue_modeled(KIND_ADD, fresh_mac(), 0);

        // random commands in alternating growth and churn stretches
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            grow = ((i / 120) % 2 == 0);
            pick = $urandom_range(99);
            if (pick < (grow ? 65 : 35))
                op = KIND_ADD;
            else if (pick < (grow ? 77 : 70))
                op = KIND_REMOVE;
            else if (pick < 99 - (grow ? 0 : 1))
                op = KIND_LOOKUP;
            else
                op = KIND_CLEAR;

            pick = $urandom_range(99);
            if (entry_total > 0 && pick < (op == KIND_ADD ? 20 : 60))
                addr = stored_mac();
            else if (pick >= 90)
                addr = (pick % 2 == 0) ? MAC_ONES : MAC_W'($urandom_range(3));
            else
                addr = random_mac();
            issue_modeled(op, addr, next_gap(RANDOM_CMDS - i));
        end
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (error_total == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/mast_pkg.sv
rtl/mast_mem.sv
rtl/mast_ctrl.sv
rtl/mac_address_set_table_unit.sv
tb/tb_mac_address_set_table_unit.sv
